/* hdl/ppid_pkg.sv */
package ppid_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TICK_WIDTH = 32;
  localparam int CFG_WIDTH  = 32;
  localparam int IN_WIDTH   = DATA_WIDTH + TICK_WIDTH;

  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic signed [DATA_WIDTH-1:0] DRIVE_MAX_RST = 32'sd65536000;
  localparam logic signed [DATA_WIDTH-1:0] DRIVE_MIN_RST = -32'sd65536000;
  localparam logic        [DATA_WIDTH-2:0] WINDUP_RST    = 31'd32768000;

  typedef enum logic [2:0] {
    REG_SETPOINT     = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_DRIVE_MAX    = 3'd4,
    REG_DRIVE_MIN    = 3'd5,
    REG_WINDUP_LIMIT = 3'd6,
    REG_SAMPLE_TICKS = 3'd7
  } cfg_reg_t;

endpackage

/* hdl/ppid_qmul.sv */
module ppid_qmul
  import ppid_pkg::*;
(
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0] p
);

  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int TOP_LO     = DATA_WIDTH - 1 + FRAC_BITS;

  logic signed [PROD_WIDTH-1:0]      prod;
  logic        [PROD_WIDTH-TOP_LO-1:0] top_bits;

  // floor of the scaled product is the arithmetic shift; saturate when the
  // bits above the result are not a pure sign extension
  assign prod     = PROD_WIDTH'(a) * PROD_WIDTH'(b);
  assign top_bits = prod[PROD_WIDTH-1:TOP_LO];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      p = prod[TOP_LO:FRAC_BITS];
    end else if (prod[PROD_WIDTH-1]) begin
      p = DATA_MIN;
    end else begin
      p = DATA_MAX;
    end
  end

endmodule

/* hdl/positional_pid_controller_unit.sv */
// Positional PID controller with integral anti-windup, signed Q16.16.
// Each input transaction carries a measured value and a free-running tick
// count; each one yields exactly one output transaction, in order. A sample
// arriving fewer than sample_ticks ticks after the last accepted one returns
// the held drive with status 1 and leaves the controller state untouched.
// The datapath is a five-register pipeline (input, error, products,
// integrator, output): a transaction is accepted every cycle unless the
// output stalls, and the three 32x32 gain multipliers work side by side in
// one stage. Configuration writes are accepted every cycle
// and must be made only while no transaction is in flight.
module positional_pid_controller_unit
  import ppid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_WIDTH-1:0]   s_tdata,   // measured [31:0], now_tick [63:32]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_WIDTH-1:0] m_tdata,   // drive [31:0]
  output logic                  m_tuser,   // status [0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_WIDTH-1:0]  cfg_data
);

  localparam int WIDE = DATA_WIDTH + 2;

  logic signed [DATA_WIDTH-1:0] setpoint, gain_p, gain_i, gain_d, drive_max, drive_min;
  logic        [DATA_WIDTH-2:0] windup_limit;
  logic        [TICK_WIDTH-1:0] sample_ticks;

  logic signed [DATA_WIDTH-1:0] integral_sum, prev_error, held_drive;
  logic        [TICK_WIDTH-1:0] last_tick;

  logic advance;
  logic v0, v1, v2, v3;

  logic signed [DATA_WIDTH-1:0] r0_meas;
  logic        [TICK_WIDTH-1:0] r0_tick;
  logic                         r1_busy, r2_busy, r3_busy;
  logic signed [DATA_WIDTH-1:0] r1_err, r1_derr;
  logic signed [DATA_WIDTH-1:0] r2_p, r2_i, r2_d;
  logic signed [DATA_WIDTH-1:0] r3_p, r3_integ, r3_d;

  logic        [TICK_WIDTH-1:0] tick_gap;
  logic                         busy_a;
  logic signed [DATA_WIDTH-1:0] err_a, derr_a;
  logic signed [DATA_WIDTH-1:0] p_b, i_b, d_b;
  logic signed [DATA_WIDTH:0]   integ_wide, lim_pos, lim_neg;
  logic signed [DATA_WIDTH-1:0] integ_c;
  logic signed [DATA_WIDTH-1:0] sum_sat, drive_d;

  function automatic logic signed [DATA_WIDTH-1:0] sat_wide(input logic signed [WIDE-1:0] v);
    if (v > WIDE'(DATA_MAX)) begin
      return DATA_MAX;
    end else if (v < WIDE'(DATA_MIN)) begin
      return DATA_MIN;
    end else begin
      return v[DATA_WIDTH-1:0];
    end
  endfunction

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign cfg_ready = 1'b1;

  // error stage: sample period check and saturated differences
  assign tick_gap = r0_tick - last_tick;
  assign busy_a   = tick_gap < sample_ticks;
  assign err_a    = sat_wide(WIDE'(setpoint) - WIDE'(r0_meas));
  assign derr_a   = sat_wide(WIDE'(err_a) - WIDE'(prev_error));

  // product stage
  ppid_qmul u_mul_p (.a(gain_p), .b(r1_err),  .p(p_b));
  ppid_qmul u_mul_i (.a(gain_i), .b(r1_err),  .p(i_b));
  ppid_qmul u_mul_d (.a(gain_d), .b(r1_derr), .p(d_b));

  // integrator stage
  assign integ_wide = (DATA_WIDTH+1)'(integral_sum) + (DATA_WIDTH+1)'(r2_i);
  assign lim_pos    = $signed({2'b00, windup_limit});
  assign lim_neg    = -lim_pos;

  always_comb begin
    if (integ_wide > lim_pos) begin
      integ_c = lim_pos[DATA_WIDTH-1:0];
    end else if (integ_wide < lim_neg) begin
      integ_c = lim_neg[DATA_WIDTH-1:0];
    end else begin
      integ_c = integ_wide[DATA_WIDTH-1:0];
    end
  end

  // output stage: sum, saturate, clamp to max then min
  assign sum_sat = sat_wide(WIDE'(r3_p) + WIDE'(r3_integ) + WIDE'(r3_d));

  always_comb begin
    drive_d = sum_sat;
    if (drive_d > drive_max) begin
      drive_d = drive_max;
    end
    if (drive_d < drive_min) begin
      drive_d = drive_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= '0;
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
      drive_max    <= DRIVE_MAX_RST;
      drive_min    <= DRIVE_MIN_RST;
      windup_limit <= WINDUP_RST;
      sample_ticks <= '0;
      integral_sum <= '0;
      prev_error   <= '0;
      held_drive   <= '0;
      last_tick    <= '0;
      v0           <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_SETPOINT:     setpoint     <= cfg_data[DATA_WIDTH-1:0];
          REG_GAIN_P:       gain_p       <= cfg_data[DATA_WIDTH-1:0];
          REG_GAIN_I:       gain_i       <= cfg_data[DATA_WIDTH-1:0];
          REG_GAIN_D:       gain_d       <= cfg_data[DATA_WIDTH-1:0];
          REG_DRIVE_MAX:    drive_max    <= cfg_data[DATA_WIDTH-1:0];
          REG_DRIVE_MIN:    drive_min    <= cfg_data[DATA_WIDTH-1:0];
          REG_WINDUP_LIMIT: windup_limit <= cfg_data[DATA_WIDTH-2:0];
          REG_SAMPLE_TICKS: sample_ticks <= cfg_data[TICK_WIDTH-1:0];
          default: ;
        endcase
      end
      if (advance) begin
        v0       <= s_tvalid;
        v1       <= v0;
        v2       <= v1;
        v3       <= v2;
        m_tvalid <= v3;
        if (v0 && !busy_a) begin
          last_tick  <= r0_tick;
          prev_error <= err_a;
        end
        if (v2 && !r2_busy) begin
          integral_sum <= integ_c;
        end
        if (v3 && !r3_busy) begin
          held_drive <= drive_d;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r0_meas  <= s_tdata[DATA_WIDTH-1:0];
      r0_tick  <= s_tdata[IN_WIDTH-1:DATA_WIDTH];
      r1_busy  <= busy_a;
      r1_err   <= err_a;
      r1_derr  <= derr_a;
      r2_busy  <= r1_busy;
      r2_p     <= p_b;
      r2_i     <= i_b;
      r2_d     <= d_b;
      r3_busy  <= r2_busy;
      r3_p     <= r2_p;
      r3_integ <= integ_c;
      r3_d     <= r2_d;
      m_tuser  <= r3_busy;
      m_tdata  <= r3_busy ? held_drive : drive_d;
    end
  end

endmodule
